/* sv/multi_queue_priority_deque_defines.svh */
// Assertion macros for the multi-queue deque block.
// Used by the RTL files under sv; needs clk and rst_n in scope.
`ifndef MULTI_QUEUE_PRIORITY_DEQUE_DEFINES_SVH
`define MULTI_QUEUE_PRIORITY_DEQUE_DEFINES_SVH

// same-cycle implication, reset masked
`define MQPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define MQPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mqpd_pkg.sv */
// Package for the multi-queue deque: field widths, codes, sequencer states.
// No dependencies.
package mqpd_pkg;

  localparam int NUM_QUEUES_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ID_WIDTH_DEF    = 16;

  localparam int CMD_W  = 2;
  localparam int QIDX_W = 5;
  localparam int ITEM_W = 16;
  localparam int CODE_W = 2;
  localparam int OCC_W  = 4;

  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE_ALT = 2'd3;

  typedef enum logic [CODE_W-1:0] {
    RES_ADDED  = 2'd0,
    RES_FULL   = 2'd1,
    RES_SERVED = 2'd2,
    RES_EMPTY  = 2'd3
  } code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_FIN
  } state_t;

endpackage

/* sv/mqpd_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on mqpd_pkg.
interface mqpd_in_if;
  import mqpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [QIDX_W-1:0] queue_index;
  logic [ITEM_W-1:0] item_id;
  modport source (output valid, output command, output queue_index, output item_id,
                  input ready);
  modport sink   (input valid, input command, input queue_index, input item_id,
                  output ready);
endinterface

interface mqpd_out_if;
  import mqpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] result_code;
  logic [ITEM_W-1:0] served_id;
  logic              served_urgent;
  logic [OCC_W-1:0]  occupancy;
  modport source (output valid, output result_code, output served_id,
                  output served_urgent, output occupancy, input ready);
  modport sink   (input valid, input result_code, input served_id,
                  input served_urgent, input occupancy, output ready);
endinterface

/* sv/multi_queue_priority_deque.sv */
// Bank of bounded deques, one per queue index, held in two block memories.
// Depends on mqpd_pkg, mqpd_if.sv and multi_queue_priority_deque_defines.svh.
//
// A request moves from accept to result register in steps: accept issues
// the read of the queue's head/count word, the next cycle decides and writes
// back head, count and (for an add) the entry, and also issues the entry
// read for a take; ST_FIN then loads the result register once it is free.
// The per-queue descriptor read followed by the entry read sets these
// steps, and a new request is taken once the previous one has reached the
// result register, even while that result still waits to be taken. Queue
// descriptors carry a valid bit each, so no clearing pass is needed after
// reset; entries read only ever come from slots written by an add.
module multi_queue_priority_deque #(
  parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqpd_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = mqpd_pkg::ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mqpd_in_if.sink     in_ch,
  mqpd_out_if.source  out_ch
);
  import mqpd_pkg::*;

  `include "multi_queue_priority_deque_defines.svh"

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MW = PW + CW;
  localparam int EW = ID_WIDTH + 1;
  localparam int AW = (NUM_QUEUES * QUEUE_DEPTH > 1) ? $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;

  // memories
  logic [MW-1:0]         meta_mem [NUM_QUEUES];
  logic [EW-1:0]         ent_mem  [NUM_QUEUES*QUEUE_DEPTH];
  logic [NUM_QUEUES-1:0] meta_vld_r;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r;
  logic [QW-1:0]       qidx_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                oob_r;
  logic [MW-1:0]       meta_rd_r;
  logic                meta_rd_vld_r;
  logic [EW-1:0]       ent_rd_r;
  code_t               code_r, code_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;

  logic                out_vld_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [ITEM_W-1:0]   out_id_r;
  logic                out_urg_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic          in_acc, out_free, out_load;
  logic [QW-1:0] qidx_in;
  logic          take, urgent, full;
  logic [PW-1:0] h, h_inc, h_dec, tail, h_n, slot;
  logic [CW-1:0] c, c_n;
  logic [SW-1:0] tsum;
  logic [AW-1:0] ent_addr;
  logic          meta_we, ent_we, ent_re;

  assign qidx_in  = QW'(in_ch.queue_index);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;

  // decode of the descriptor read back
  assign take   = (cmd_r == CMD_TAKE) || (cmd_r == CMD_TAKE_ALT);
  assign urgent = (cmd_r == CMD_ADD_HEAD);
  assign h      = meta_rd_vld_r ? meta_rd_r[MW-1:CW] : '0;
  assign c      = meta_rd_vld_r ? meta_rd_r[CW-1:0]  : '0;
  assign full   = (c >= CW'(QUEUE_DEPTH));
  assign h_inc  = (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  assign h_dec  = (h == '0) ? PW'(QUEUE_DEPTH - 1) : h - 1'b1;
  assign tsum   = SW'(h) + SW'(c);
  assign tail   = (tsum >= SW'(QUEUE_DEPTH)) ? PW'(tsum - SW'(QUEUE_DEPTH)) : PW'(tsum);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    occ_nxt   = occ_r;
    meta_we   = 1'b0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    h_n       = h;
    c_n       = c;
    slot      = h;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_META;
        end
      end
      ST_META: begin
        state_nxt = ST_FIN;
        occ_nxt   = OCC_W'(c);
        if (oob_r) begin
          code_nxt = take ? RES_EMPTY : RES_FULL;
          occ_nxt  = '0;
        end else if (take) begin
          if (c == '0) begin
            code_nxt = RES_EMPTY;
          end else begin
            code_nxt = RES_SERVED;
            ent_re   = 1'b1;
            h_n      = h_inc;
            c_n      = c - 1'b1;
            meta_we  = 1'b1;
            occ_nxt  = OCC_W'(c_n);
          end
        end else if (full) begin
          code_nxt = RES_FULL;
        end else begin
          code_nxt = RES_ADDED;
          ent_we   = 1'b1;
          meta_we  = 1'b1;
          c_n      = c + 1'b1;
          occ_nxt  = OCC_W'(c_n);
          if (urgent) begin
            h_n  = h_dec;
            slot = h_dec;
          end else begin
            slot = tail;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ent_addr = AW'(qidx_r) * AW'(QUEUE_DEPTH) + AW'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and descriptor read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r         <= in_ch.command;
      qidx_r        <= qidx_in;
      id_r          <= ID_WIDTH'(in_ch.item_id);
      oob_r         <= (32'(in_ch.queue_index) >= NUM_QUEUES);
      meta_rd_r     <= meta_mem[qidx_in];
      meta_rd_vld_r <= meta_vld_r[qidx_in];
    end
    code_r <= code_nxt;
    occ_r  <= occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[qidx_r] <= {h_n, c_n};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
    end else if (meta_we) begin
      meta_vld_r[qidx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= {urgent, id_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= code_r;
      out_occ_r  <= occ_r;
      if (code_r == RES_SERVED) begin
        out_id_r  <= ITEM_W'(ent_rd_r[ID_WIDTH-1:0]);
        out_urg_r <= ent_rd_r[ID_WIDTH];
      end else begin
        out_id_r  <= '0;
        out_urg_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.result_code   = out_code_r;
  assign out_ch.served_id     = out_id_r;
  assign out_ch.served_urgent = out_urg_r;
  assign out_ch.occupancy     = out_occ_r;

  `MQPD_ASSERT_NEXT(a_acc_to_meta, in_acc, state_r == ST_META, "accept did not start lookup")
  `MQPD_ASSERT_NOW(a_cnt_bound, (state_r == ST_META) && meta_rd_vld_r, c <= CW'(QUEUE_DEPTH), "count above depth")
  `MQPD_ASSERT_NOW(a_write_not_take, ent_we, !take && !oob_r && !full, "entry write on take, full or bad queue")
  `MQPD_ASSERT_NOW(a_served_clean, out_vld_r && (out_code_r != RES_SERVED), (out_id_r == '0) && !out_urg_r, "served fields set without service")

endmodule
